// ===== rtl/three_term_recurrence_checksum_defines.svh =====
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_DEFINES_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset
`define TTRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttrc check failed");

// Next-cycle implication, checked on clk_i outside reset
`define TTRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttrc check failed");

`endif

// ===== rtl/ttrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttrc_pkg;

  localparam int unsigned TermW = 16;
  localparam int unsigned CoefW = 8;
  localparam int unsigned SumW  = 26;

  localparam logic [TermW-1:0] FirstOffset = 16'd7;
  localparam logic [TermW-1:0] TermReset   = 16'd1;
  localparam logic [CoefW-1:0] AlphaStep   = 8'd17;
  localparam logic [CoefW-1:0] BetaStep    = 8'd31;
  localparam logic [TermW-1:0] Modulus     = 16'hFFFF;
  // 256 * 65535: keeps the biased difference non-negative, same residue
  localparam logic [SumW-1:0]  SumBias     = 26'(256 * 65535);

  typedef struct packed {
    logic             in_msg;
    logic [CoefW-1:0] alpha;   // 17*i mod 256
    logic [CoefW-1:0] beta;    // 31*i mod 256
    logic [TermW-1:0] prev;
    logic [TermW-1:0] cur;
  } ttrc_state_t;

  localparam ttrc_state_t StateReset = '{
    in_msg: 1'b0,
    alpha:  '0,
    beta:   '0,
    prev:   TermReset,
    cur:    TermReset
  };

endpackage

`default_nettype wire

// ===== rtl/ttrc_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Residue of a non-negative sum modulo 2^16 - 1 by end-around folding
module ttrc_mod import ttrc_pkg::*; (
  input  wire logic [SumW-1:0]  sum_i,
  output logic      [TermW-1:0] res_o
);

  logic [TermW:0] fold1;
  logic [TermW:0] fold2;

  always_comb begin
    fold1 = 17'(sum_i[SumW-1:TermW]) + {1'b0, sum_i[TermW-1:0]};
    // carry out of fold1 only occurs with a small low half, so fold2 fits 16 bits
    fold2 = {1'b0, fold1[TermW-1:0]} + 17'(fold1[TermW]);
    if (fold2 >= {1'b0, Modulus}) begin
      res_o = TermW'(fold2 - {1'b0, Modulus});
    end else begin
      res_o = fold2[TermW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttrc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One recurrence step: next state from the current state and a message byte
module ttrc_step import ttrc_pkg::*; (
  input  wire  ttrc_state_t state_i,
  input  wire  logic [7:0]  data_byte_i,
  output ttrc_state_t       state_o
);

  logic [8:0]      factor;
  logic [24:0]     plus;
  logic [23:0]     minus;
  logic            neg;
  logic [SumW-1:0] biased;
  logic [TermW-1:0] next_term;

  always_comb begin
    factor = {1'b0, data_byte_i} + {1'b0, state_i.alpha};
    plus   = 25'(factor) * 25'(state_i.cur);
    minus  = 24'(state_i.beta) * 24'(state_i.prev);
    neg    = plus < 25'(minus);
    // 64-bit wrap of a negative difference adds one modulo 2^16 - 1
    biased = 26'(plus) - 26'(minus) + SumBias + 26'(neg);
  end

  ttrc_mod u_mod (
    .sum_i (biased),
    .res_o (next_term)
  );

  always_comb begin
    if (!state_i.in_msg) begin
      state_o.in_msg = 1'b1;
      state_o.alpha  = AlphaStep;
      state_o.beta   = BetaStep;
      state_o.prev   = TermReset;
      state_o.cur    = 16'(data_byte_i) + FirstOffset;
    end else begin
      state_o.in_msg = 1'b1;
      state_o.alpha  = state_i.alpha + AlphaStep;
      state_o.beta   = state_i.beta + BetaStep;
      state_o.prev   = state_i.cur;
      state_o.cur    = next_term;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/three_term_recurrence_checksum.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | data_byte_i[7:0], last_i
// out     | output    | out_valid_o / out_stall_i | checksum_o[15:0]
//
// One byte per cycle unless stalled; the recurrence state updates at the edge a byte is taken.
// The cycle time is set by the two term multipliers and the mod 65535 fold.
// A checksum appears in the cycle after its last byte is taken, held in the output register.
// Reset puts the recurrence back at the start of a message; no result pending.
// A waiting checksum stalls only a byte marked last; other bytes keep flowing.
`timescale 1ns / 1ps
`default_nettype none

`include "three_term_recurrence_checksum_defines.svh"

module three_term_recurrence_checksum import ttrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] checksum_o
);

  ttrc_state_t state_q;
  ttrc_state_t state_d;
  ttrc_state_t step_state;
  logic        out_valid_q;
  logic [15:0] checksum_q;
  logic        in_acc;

  ttrc_step u_step (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .state_o     (step_state)
  );

  assign in_stall_o = out_valid_q & out_stall_i & last_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      state_d = last_i ? StateReset : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && last_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_i) begin
      checksum_q <= step_state.cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

  `TTRC_ASSERT_NEXT(a_last_gives_word, in_acc && last_i, out_valid_o && !state_q.in_msg)
  `TTRC_ASSERT_NOW(a_checksum_range, out_valid_o, checksum_o != Modulus)
  `TTRC_ASSERT_NOW(a_coef_track, state_q.in_msg,
                   8'(state_q.alpha * BetaStep) == 8'(state_q.beta * AlphaStep))
  `TTRC_ASSERT_NOW(a_idle_terms, !state_q.in_msg,
                   state_q.prev == TermReset && state_q.cur == TermReset)
  `TTRC_ASSERT_NEXT(a_word_held, out_valid_o && out_stall_i, out_valid_o && $stable(checksum_o))

endmodule

`default_nettype wire

// ===== test/three_term_recurrence_checksum_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, tracks the recurrence for every word taken on the
// input side and compares each checksum taken on the output side in order.
module three_term_recurrence_checksum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] checksum_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [15:0] StartBias = 16'd7;
  localparam logic [15:0] TermInit  = 16'd1;
  localparam logic [7:0]  AlphaIncr = 8'd17;
  localparam logic [7:0]  BetaIncr  = 8'd31;
  localparam logic [63:0] Fold      = 64'd65535;
  localparam int          ReportMax = 10;

  logic [15:0] term_prev;
  logic [15:0] term_cur;
  logic [15:0] term_next;
  logic [7:0]  position;
  logic        mid_message;
  logic [15:0] want;
  logic [15:0] checksum_q[$];

  // One recurrence step; the difference wraps at 64 bits before the fold.
  function automatic logic [15:0] next_term(input logic [7:0] b, input logic [7:0] idx,
                                            input logic [15:0] cur, input logic [15:0] prev);
    logic [7:0]  alpha;
    logic [7:0]  beta;
    logic [63:0] gain;
    logic [63:0] loss;
    alpha = idx * AlphaIncr;
    beta  = idx * BetaIncr;
    gain  = ({56'd0, b} + {56'd0, alpha}) * {48'd0, cur};
    loss  = {56'd0, beta} * {48'd0, prev};
    return 16'((gain - loss) % Fold);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_prev    = TermInit;
      term_cur     = TermInit;
      position     = '0;
      mid_message  = 1'b0;
      checksum_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // output word first: it always belongs to an earlier input word
      if (out_valid_i && !out_stall_i) begin
        if (checksum_q.size() == 0) begin
          if (fail_count_o < ReportMax)
            $display("checker: checksum %0d with none expected", checksum_i);
          fail_count_o++;
        end else begin
          want = checksum_q.pop_front();
          if (checksum_i !== want) begin
            if (fail_count_o < ReportMax)
              $display("checker: checksum expected %0d, got %0d", want, checksum_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!mid_message) begin
          term_prev   = TermInit;
          term_cur    = 16'(data_byte_i) + StartBias;
          position    = 8'd1;
          mid_message = 1'b1;
        end else begin
          term_next = next_term(data_byte_i, position, term_cur, term_prev);
          term_prev = term_cur;
          term_cur  = term_next;
          position  = position + 8'd1;
        end
        if (last_i) begin
          checksum_q.push_back(term_cur);
          term_prev   = TermInit;
          term_cur    = TermInit;
          position    = '0;
          mid_message = 1'b0;
        end
      end
      pending_o = checksum_q.size();
    end
  end

endmodule

// ===== test/tb_three_term_recurrence_checksum.sv =====
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum;

  localparam int RandomItems = 530;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 200000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_i      = 1'b0;
  logic        out_stall_i = 1'b0;
  wire logic        in_stall_o;
  wire logic        out_valid_o;
  wire logic [15:0] checksum_o;

  int fail_count;
  int pending;
  int cycle_count;
  int burst_left = 0;
  bit hold_pending = 1'b0;
  bit hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  three_term_recurrence_checksum u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o)
  );

  three_term_recurrence_checksum_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .checksum_i   (checksum_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one word, wait until it is taken, then maybe idle a while.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    int r;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        burst_left = $urandom_range(10, 30);
        gap = 0;
      end else if (r < 55) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 50);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int total;
    int len;
    int r;
    logic [7:0] b;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-word and short messages of bytes 00 and FF, then one of mixed bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h55, 1'b1);

    // first a message long enough to wrap the byte index, then short ones
    total = 0;
    len = $urandom_range(258, 300);
    while (total < RandomItems) begin
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 2) b = 8'h00;
        else if (r < 4) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        send_byte(b, (i == len - 1));
      end
      total += len;
      hold_pending = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 8) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 40);
    end
    in_valid_i <= 1'b0;
    // let the checker log the final word before looking at its count
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_three_term_recurrence_checksum: done, clean");
    end else begin
      $display("tb_three_term_recurrence_checksum: done, errors");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the input backs up.
  initial begin
    int r;
    int span;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_pending && !hold_done) begin
        out_stall_i <= 1'b1;
        span = HoldCycles;
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          out_stall_i <= 1'b0;
          span = $urandom_range(1, 20);
        end else if (r < 9) begin
          out_stall_i <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          span = $urandom_range(20, 60);
        end
      end
      repeat (span) @(posedge clk_i);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_three_term_recurrence_checksum: done, errors");
    $finish;
  end

endmodule
